>>> hdl/hpq_pkg.sv
// hpq_pkg: shared types and codes for the min-heap priority queue
// transaction structs, heap entry type, command and status codes
// no dependencies
`default_nettype none

package hpq_pkg;

    localparam int KEY_WIDTH   = 32;
    localparam int NODE_WIDTH  = 16;
    localparam int COUNT_WIDTH = 7;

    localparam logic       CMD_PUSH  = 1'b0;
    localparam logic       CMD_POP   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_WIDTH-1:0]  key;
        logic [NODE_WIDTH-1:0] node;
    } req_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   top_key;
        logic [NODE_WIDTH-1:0]  top_node;
        logic                   top_valid;
        logic [COUNT_WIDTH-1:0] count;
        logic [1:0]             status;
    } rsp_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]  key;
        logic [NODE_WIDTH-1:0] node;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/min_heap_priority_queue.sv
// min_heap_priority_queue: binary min-heap of (key, node) entries
// depends on hpq_pkg, hpq_mem and hpq_cmp
`default_nettype none

// usage
//   request channel req_valid / req_stall / req carries one command per
//   transaction: push (key, node) or pop the minimum entry
//   response channel rsp_valid / rsp_stall / rsp returns one transaction per
//   request: current minimum entry, valid flag, entry count and status
//   a push walks up one level per cycle through the parent read and the
//   shared comparator; the first push into an empty heap goes straight to
//   the root, and an empty pop or a full push goes straight to the response
//   a pop reads the last entry, then at each level compares the child pair,
//   then the chosen child against the moving entry; a pop that empties the
//   heap goes straight to the response once the last entry is read
//   one command is in flight at a time; req_stall is high while it is worked
//   and drops as rsp_valid rises
//   the response sits in an output register, so the next request is taken
//   while rsp_stall holds a finished response; a later command waits at its
//   end until that register is free
//   reset empties the heap at once (count to zero); storage keeps no reset
module min_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire hpq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output hpq_pkg::rsp_t      rsp
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // child indexes reach 2*CAPACITY
    localparam int IW     = ADDR_W + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_CMP   = 3'd1;
    localparam logic [2:0] S_UP_FIN   = 3'd2;
    localparam logic [2:0] S_POP_LAST = 3'd3;
    localparam logic [2:0] S_DN_LR    = 3'd4;
    localparam logic [2:0] S_DN_X     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [ADDR_W-1:0] cur_reg,    cur_next;
    logic [ADDR_W-1:0] pick_idx_reg, pick_idx_next;
    logic [1:0]        status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;

    hpq_pkg::entry_t   x_reg,    x_next;      // entry being sifted
    hpq_pkg::entry_t   pick_reg, pick_next;   // chosen child on pop
    hpq_pkg::entry_t   top_reg,  top_next;    // mirror of the root entry
    hpq_pkg::rsp_t     rsp_reg,  rsp_next;

    // storage ports
    logic              we;
    logic [ADDR_W-1:0] wa;
    hpq_pkg::entry_t   wd;
    logic [ADDR_W-1:0] ra0;
    logic [ADDR_W-1:0] ra1;
    hpq_pkg::entry_t   rd0;
    hpq_pkg::entry_t   rd1;

    // shared comparator
    logic [hpq_pkg::KEY_WIDTH-1:0] cmp_a;
    logic [hpq_pkg::KEY_WIDTH-1:0] cmp_b;
    logic                          cmp_lt;

    // index arithmetic
    logic [ADDR_W-1:0] cnt_last;
    logic [ADDR_W-1:0] cnt_parent;
    logic [ADDR_W-1:0] cur_parent;
    logic [ADDR_W-1:0] cur_grand;
    logic [IW-1:0]     cur_left;
    logic [IW-1:0]     cur_right;
    logic [IW-1:0]     pick_left;
    logic [IW-1:0]     pick_right;
    logic [IW-1:0]     cnt_ext;

    hpq_pkg::entry_t   req_entry;
    logic              heap_full;

    hpq_mem #(
        .DEPTH(CAPACITY),
        .AW   (ADDR_W)
    ) u_mem (
        .clk(clk),
        .we (we),
        .wa (wa),
        .wd (wd),
        .ra0(ra0),
        .ra1(ra1),
        .rd0(rd0),
        .rd1(rd1)
    );

    hpq_cmp u_cmp (
        .a (cmp_a),
        .b (cmp_b),
        .lt(cmp_lt)
    );

    assign cnt_last   = ADDR_W'(cnt_reg - 1'b1);
    assign cnt_parent = ADDR_W'((cnt_reg - 1'b1) >> 1);
    assign cur_parent = (cur_reg - 1'b1) >> 1;
    assign cur_grand  = (cur_parent - 1'b1) >> 1;
    assign cur_left   = IW'({cur_reg, 1'b1});
    assign cur_right  = cur_left + 1'b1;
    assign pick_left  = IW'({pick_idx_reg, 1'b1});
    assign pick_right = pick_left + 1'b1;
    assign cnt_ext    = IW'(cnt_reg);
    assign heap_full  = (cnt_reg == CNT_W'(CAPACITY));

    assign req_entry = {req.key, req.node};

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        pick_idx_next  = pick_idx_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        x_next         = x_reg;
        pick_next      = pick_reg;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        wa             = cur_reg;
        wd             = x_reg;
        ra0            = '0;
        ra1            = '0;
        cmp_a          = x_reg.key;
        cmp_b          = rd0.key;

        // response taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // pop reads the last entry, push reads the new slot's parent
                ra0 = (req.cmd == hpq_pkg::CMD_POP) ? cnt_last : cnt_parent;
                if (req_valid)
                begin
                    x_next      = req_entry;
                    status_next = hpq_pkg::ST_OK;
                    if (req.cmd == hpq_pkg::CMD_POP)
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = hpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_POP_LAST;
                        end
                    end
                    else if (heap_full)
                    begin
                        status_next = hpq_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        cur_next = ADDR_W'(cnt_reg);
                        if (cnt_reg == '0)
                        begin
                            // first entry goes straight to the root
                            we         = 1'b1;
                            wa         = '0;
                            wd         = req_entry;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_UP_CMP;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                cmp_a = x_reg.key;
                cmp_b = rd0.key;
                we    = 1'b1;
                wa    = cur_reg;
                if (cmp_lt)
                begin
                    // parent moves down into the hole
                    wd       = rd0;
                    cur_next = cur_parent;
                    ra0      = cur_grand;
                    if (cur_parent == '0)
                    begin
                        state_next = S_UP_FIN;
                    end
                end
                else
                begin
                    wd         = x_reg;
                    state_next = S_DONE;
                end
            end

            S_UP_FIN:
            begin
                we         = 1'b1;
                wa         = cur_reg;
                wd         = x_reg;
                state_next = S_DONE;
            end

            S_POP_LAST:
            begin
                x_next = rd0;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = '0;
                    ra0        = ADDR_W'(1);
                    ra1        = ADDR_W'(2);
                    state_next = S_DN_LR;
                end
            end

            S_DN_LR:
            begin
                cmp_a = rd0.key;
                cmp_b = rd1.key;
                if (cur_left >= cnt_ext)
                begin
                    // leaf reached
                    we         = 1'b1;
                    wa         = cur_reg;
                    wd         = x_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    // equal children take the right one
                    if ((cur_right < cnt_ext) && !cmp_lt)
                    begin
                        pick_next     = rd1;
                        pick_idx_next = ADDR_W'(cur_right);
                    end
                    else
                    begin
                        pick_next     = rd0;
                        pick_idx_next = ADDR_W'(cur_left);
                    end
                    state_next = S_DN_X;
                end
            end

            S_DN_X:
            begin
                cmp_a = pick_reg.key;
                cmp_b = x_reg.key;
                we    = 1'b1;
                wa    = cur_reg;
                if (cmp_lt)
                begin
                    wd         = pick_reg;
                    cur_next   = pick_idx_reg;
                    ra0        = ADDR_W'(pick_left);
                    ra1        = ADDR_W'(pick_right);
                    state_next = S_DN_LR;
                end
                else
                begin
                    wd         = x_reg;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.top_valid = (cnt_reg != '0);
                    rsp_next.top_key   = (cnt_reg != '0) ? top_reg.key : '0;
                    rsp_next.top_node  = (cnt_reg != '0) ? top_reg.node : '0;
                    rsp_next.count     = hpq_pkg::COUNT_WIDTH'(cnt_reg);
                    rsp_next.status    = status_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root mirror follows every write to address zero
    always_comb
    begin
        top_next = top_reg;
        if (we && (wa == '0))
        begin
            top_next = wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pick_idx_reg <= pick_idx_next;
        status_reg   <= status_next;
        x_reg        <= x_next;
        pick_reg     <= pick_next;
        top_reg      <= top_next;
        rsp_reg      <= rsp_next;
    end

endmodule

`default_nettype wire

>>> hdl/hpq_mem.sv
// hpq_mem: heap entry storage, one write port and two registered read ports
// depends on hpq_pkg for the entry type
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   wa,
    input  wire hpq_pkg::entry_t wd,
    input  wire logic [AW-1:0]   ra0,
    input  wire logic [AW-1:0]   ra1,
    output hpq_pkg::entry_t      rd0,
    output hpq_pkg::entry_t      rd1
);

    hpq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0 <= mem[ra0];
        rd1 <= mem[ra1];
    end

endmodule

`default_nettype wire

>>> hdl/hpq_cmp.sv
// hpq_cmp: shared unsigned key comparator used by every sift step
// depends on hpq_pkg for the key width
`default_nettype none

module hpq_cmp (
    input  wire logic [hpq_pkg::KEY_WIDTH-1:0] a,
    input  wire logic [hpq_pkg::KEY_WIDTH-1:0] b,
    output logic                               lt
);

    // strict less-than, ties never count as smaller
    assign lt = (a < b);

endmodule

`default_nettype wire

>>> hdl/hpq_checker.sv
// hpq_checker: port-level assertions for min_heap_priority_queue
// depends on hpq_pkg; bound to the top level below
`default_nettype none

module hpq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire hpq_pkg::rsp_t rsp
);

    // an empty heap shows zero top fields
    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.top_valid) |-> (rsp.top_key == '0 && rsp.top_node == '0))
        else $error("empty heap response carries a nonzero top entry");

    // a rejected pop only happens on an empty heap
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == hpq_pkg::ST_EMPTY) |-> (!rsp.top_valid && rsp.count == '0))
        else $error("pop-empty status with a nonempty heap");

    // a dropped push never reports an empty heap
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == hpq_pkg::ST_FULL) |-> rsp.top_valid)
        else $error("push-full status with an empty heap");

    // req_stall rises after each accepted command, so no two are accepted back to back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted on back-to-back cycles");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind min_heap_priority_queue hpq_checker u_hpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);

`default_nettype wire

>>> dv/tb.sv
// tb: self-checking testbench for min_heap_priority_queue
// drives push/pop transactions with random idling on both channels and checks
// every response against an in-bench predictor or typed-in want; depends on hpq_pkg
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = 64;
    // normal runs finish far sooner; this only catches a hung handshake
    localparam int RUN_LIMIT   = 5_000_000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PRINT_CAP   = 40;

    // random bursts either mix pushes and pops or run the heap to full / empty
    typedef enum {MIX, FILL, DRAIN} stim_mode_t;

    // one row of the directed table: the request and, where it is obvious,
    // the response typed in by hand
    typedef struct {
        hpq_pkg::req_t stim;
        bit            fixed;
        hpq_pkg::rsp_t want;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    hpq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    hpq_pkg::rsp_t rsp;

    // predictor state: heap storage and entry count
    logic [hpq_pkg::KEY_WIDTH-1:0]  heap_key  [HEAP_DEPTH];
    logic [hpq_pkg::NODE_WIDTH-1:0] heap_node [HEAP_DEPTH];
    int unsigned                    heap_count = 0;

    // responses still owed by the block, oldest first
    hpq_pkg::rsp_t heap_replies_due [$];
    dir_row_t      dir_rows [$];
    int unsigned   mismatches = 0;

    min_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block never answers
    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [hpq_pkg::KEY_WIDTH-1:0]  tk;
        logic [hpq_pkg::NODE_WIDTH-1:0] tn;
        tk           = heap_key[a];
        tn           = heap_node[a];
        heap_key[a]  = heap_key[b];
        heap_node[a] = heap_node[b];
        heap_key[b]  = tk;
        heap_node[b] = tn;
    endfunction

    // applies one command to the predictor heap and returns the response
    function automatic hpq_pkg::rsp_t heap_apply(hpq_pkg::req_t item);
        hpq_pkg::rsp_t res;
        int unsigned   cur;
        int unsigned   par;
        int unsigned   lc;
        int unsigned   rc;
        int unsigned   pick;
        bit            walking;
        res        = '0;
        res.status = hpq_pkg::ST_OK;
        if (item.cmd == hpq_pkg::CMD_POP)
        begin
            if (heap_count == 0)
                res.status = hpq_pkg::ST_EMPTY;
            else
            begin
                // last entry moves to the root, then sifts down
                heap_count--;
                swap_slots(0, heap_count);
                cur     = 0;
                walking = 1'b1;
                while (walking)
                begin
                    lc = 2 * cur + 1;
                    rc = lc + 1;
                    // a tie between children goes to the right one
                    if (rc < heap_count)
                        pick = (heap_key[lc] < heap_key[rc]) ? lc : rc;
                    else if (lc < heap_count)
                        pick = lc;
                    else
                        pick = cur;
                    if (pick != cur && heap_key[pick] < heap_key[cur])
                    begin
                        swap_slots(cur, pick);
                        cur = pick;
                    end
                    else
                        walking = 1'b0;
                end
            end
        end
        else if (heap_count >= HEAP_DEPTH)
            res.status = hpq_pkg::ST_FULL;
        else
        begin
            // append and sift up while strictly smaller than the parent
            cur             = heap_count;
            heap_key[cur]   = item.key;
            heap_node[cur]  = item.node;
            heap_count++;
            while (cur != 0)
            begin
                par = (cur - 1) / 2;
                if (heap_key[cur] < heap_key[par])
                begin
                    swap_slots(cur, par);
                    cur = par;
                end
                else
                    break;
            end
        end
        if (heap_count != 0)
        begin
            res.top_key   = heap_key[0];
            res.top_node  = heap_node[0];
            res.top_valid = 1'b1;
        end
        res.count = hpq_pkg::COUNT_WIDTH'(heap_count);
        return res;
    endfunction

    function automatic void add_row(logic c, logic [hpq_pkg::KEY_WIDTH-1:0] k,
                                    logic [hpq_pkg::NODE_WIDTH-1:0] n, bit fixed,
                                    hpq_pkg::rsp_t want);
        dir_row_t row;
        row.stim.cmd  = c;
        row.stim.key  = k;
        row.stim.node = n;
        row.fixed     = fixed;
        row.want      = want;
        dir_rows      = {dir_rows, row};
    endfunction

    // one request transaction; the prediction is made once it is accepted
    task automatic send_req(input hpq_pkg::req_t item, input int unsigned gap,
                            input bit fixed, input hpq_pkg::rsp_t want);
        hpq_pkg::rsp_t predicted;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        predicted = heap_apply(item);
        heap_replies_due = {heap_replies_due, (fixed ? want : predicted)};
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    // response side: check each accepted transaction, then pick the next stall
    initial
    begin : rsp_side
        hpq_pkg::rsp_t want;
        int unsigned   hold;
        hold = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (heap_replies_due.size() == 0)
                begin
                    if (mismatches < PRINT_CAP)
                        $display("%0t: unexpected response, expected none, actual %h",
                                 $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = heap_replies_due.pop_front();
                    if (rsp.top_key !== want.top_key)
                        report_field("top_key", want.top_key, rsp.top_key);
                    if (rsp.top_node !== want.top_node)
                        report_field("top_node", want.top_node, rsp.top_node);
                    if (rsp.top_valid !== want.top_valid)
                        report_field("top_valid", want.top_valid, rsp.top_valid);
                    if (rsp.count !== want.count)
                        report_field("count", want.count, rsp.count);
                    if (rsp.status !== want.status)
                        report_field("status", want.status, rsp.status);
                end
            end
            // stall pattern: short or long stalls, separated by open stretches
            if (hold != 0)
                hold--;
            else if (rsp_stall)
            begin
                rsp_stall <= 1'b0;
                hold = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100)
                                                   : $urandom_range(0, 6);
            end
            else
            begin
                hold = pick_gap();
                if (hold != 0)
                begin
                    rsp_stall <= 1'b1;
                    hold--;
                end
            end
        end
    end

    // request side: reset, directed table, random bursts, drain
    initial
    begin : stimulus
        hpq_pkg::req_t item;
        stim_mode_t    mode;
        int unsigned   burst_len;
        int unsigned   push_pct;
        int unsigned   rand_sent;
        int unsigned   phase;
        bit            no_gaps;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // pop on an empty heap right after reset
        add_row(hpq_pkg::CMD_POP,  32'd0,  16'd0, 1'b1,
                {32'd0,  16'd0, 1'b0, 7'd0, hpq_pkg::ST_EMPTY});
        add_row(hpq_pkg::CMD_PUSH, 32'd10, 16'd1, 1'b1,
                {32'd10, 16'd1, 1'b1, 7'd1, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_PUSH, 32'd20, 16'd2, 1'b1,
                {32'd10, 16'd1, 1'b1, 7'd2, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_PUSH, 32'd20, 16'd3, 1'b1,
                {32'd10, 16'd1, 1'b1, 7'd3, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_PUSH, 32'd30, 16'd4, 1'b1,
                {32'd10, 16'd1, 1'b1, 7'd4, hpq_pkg::ST_OK});
        // equal children 20/2 and 20/3: the right child wins
        add_row(hpq_pkg::CMD_POP,  32'd0,  16'd0, 1'b1,
                {32'd20, 16'd3, 1'b1, 7'd3, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_POP,  32'd0,  16'd0, 1'b0, '0);
        // key and node bits on a pop must be ignored
        add_row(hpq_pkg::CMD_POP,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0);
        add_row(hpq_pkg::CMD_POP,  32'd0,  16'd0, 1'b1,
                {32'd0,  16'd0, 1'b0, 7'd0, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_POP,  32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                {32'd0, 16'd0, 1'b0, 7'd0, hpq_pkg::ST_EMPTY});
        // largest key and node
        add_row(hpq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                {32'hFFFF_FFFF, 16'hFFFF, 1'b1, 7'd1, hpq_pkg::ST_OK});
        // key equal to its parent stays below
        add_row(hpq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'h0000, 1'b1,
                {32'hFFFF_FFFF, 16'hFFFF, 1'b1, 7'd2, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_PUSH, 32'd0, 16'd0, 1'b1,
                {32'd0, 16'd0, 1'b1, 7'd3, hpq_pkg::ST_OK});
        add_row(hpq_pkg::CMD_PUSH, 32'h0000_0001, 16'h8000, 1'b0, '0);
        add_row(hpq_pkg::CMD_PUSH, 32'h8000_0000, 16'h5555, 1'b0, '0);
        add_row(hpq_pkg::CMD_PUSH, 32'h5555_5555, 16'hAAAA, 1'b0, '0);
        add_row(hpq_pkg::CMD_PUSH, 32'hAAAA_AAAA, 16'h0001, 1'b0, '0);
        add_row(hpq_pkg::CMD_PUSH, 32'h0001_0000, 16'h7FFF, 1'b0, '0);
        add_row(hpq_pkg::CMD_POP,  32'd0, 16'd0, 1'b0, '0);
        add_row(hpq_pkg::CMD_POP,  32'd0, 16'd0, 1'b0, '0);
        add_row(hpq_pkg::CMD_POP,  32'd0, 16'd0, 1'b0, '0);
        add_row(hpq_pkg::CMD_POP,  32'd0, 16'd0, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].stim, pick_gap(), dir_rows[i].fixed, dir_rows[i].want);

        // random bursts; the second burst fills the heap past full, the third
        // empties it past empty, later ones are mostly mixed
        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (phase == 0 || $urandom_range(0, 3) == 0)
            begin
                // hold off until every outstanding transaction has answered
                req_valid <= 1'b0;
                do @(posedge clk); while (heap_replies_due.size() != 0);
            end
            if (phase == 1)
                mode = FILL;
            else if (phase == 2)
                mode = DRAIN;
            else if ($urandom_range(0, 3) == 0)
                mode = $urandom_range(0, 1) ? FILL : DRAIN;
            else
                mode = MIX;
            no_gaps = ($urandom_range(0, 3) == 0);
            case (mode)
                FILL:
                begin
                    burst_len = HEAP_DEPTH - heap_count + $urandom_range(2, 8);
                    push_pct  = 100;
                end
                DRAIN:
                begin
                    burst_len = heap_count + $urandom_range(2, 6);
                    push_pct  = 0;
                end
                default:
                begin
                    burst_len = $urandom_range(20, 60);
                    push_pct  = $urandom_range(30, 75);
                end
            endcase
            repeat (burst_len)
            begin
                item.cmd = ($urandom_range(0, 99) < push_pct) ? hpq_pkg::CMD_PUSH
                                                              : hpq_pkg::CMD_POP;
                // keys: full range, tiny values for ties, whole Q16.16 units, extremes
                case ($urandom_range(0, 9))
                    5, 6:    item.key = $urandom_range(0, 7);
                    7:       item.key = {16'($urandom_range(0, 100)), 16'h0000};
                    8:       item.key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    9:       item.key = 32'hFFFF_FFFC + $urandom_range(0, 3);
                    default: item.key = $urandom;
                endcase
                if ($urandom_range(0, 4) == 0)
                    item.node = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    item.node = 16'($urandom_range(0, 65535));
                send_req(item, no_gaps ? 0 : pick_gap(), 1'b0, '0);
                rand_sent++;
            end
            phase++;
        end

        // drain, then wait for stray responses
        req_valid <= 1'b0;
        do @(posedge clk); while (heap_replies_due.size() != 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
